// File: src/srp_pkg.sv
// Shared types, constants and helper functions for the star rotate and project block.
package srp_pkg;

    // Default number of stars held in the point store.
    localparam int unsigned STAR_COUNT_DEF = 128;

    // Field widths.
    localparam int unsigned IDX_IN_W = 7;
    localparam int unsigned COORD_W  = 10;
    localparam int unsigned ROT_W    = 11;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CTR_W    = 10;
    localparam int unsigned SCR_W    = 12;
    localparam int unsigned SHADE_W  = 8;
    localparam int unsigned POINT_W  = 3 * ROT_W;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 56;

    // Divider geometry: |256*v| needs 19 bits, |z - 1024| needs 12 bits.
    localparam int unsigned NUM_W = 19;
    localparam int unsigned DEN_W = 12;

    // Rotation arithmetic.
    localparam int unsigned PROD_W  = 28;
    localparam int unsigned Q14_SH  = 14;
    localparam int          ROT_MAX = 1023;
    localparam int          ROT_MIN = -1024;

    // Projection and shade constants.
    localparam int unsigned PROJ_SH     = 8;
    localparam int          DEPTH_OFS   = 1024;
    localparam int          SHADE_OFS   = 721;
    localparam int unsigned SHADE_RECIP = 5958;
    localparam int unsigned SHADE_SH    = 16;
    localparam int          SCR_MAX     = 2047;
    localparam int          SCR_MIN     = -2048;
    localparam int unsigned SUM_W       = 21;

    // Configuration register reset values.
    localparam logic signed [CFG_W-1:0] COS_RST = 16'sd16384;
    localparam logic signed [CFG_W-1:0] SIN_RST = 16'sd0;
    localparam logic [CTR_W-1:0]        CX_RST  = 10'd320;
    localparam logic [CTR_W-1:0]        CY_RST  = 10'd240;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_COS = 2'd0,
        REG_SIN = 2'd1,
        REG_CX  = 2'd2,
        REG_CY  = 2'd3
    } cfg_reg_t;

    // Reduce a star index modulo the store depth by conditional subtraction.
    function automatic logic [IDX_IN_W-1:0] idx_mod(input logic [IDX_IN_W-1:0] v,
                                                    input int unsigned n);
        logic [19:0] r;
        r = {13'd0, v};
        for (int k = IDX_IN_W - 1; k >= 0; k--) begin
            if (r >= (20'(n) << k)) begin
                r = r - (20'(n) << k);
            end
        end
        return r[IDX_IN_W-1:0];
    endfunction

endpackage

// File: src/srp_store.sv
// Point store: one synchronous memory of rotated points with a clearing pass after reset.
module srp_store #(
    parameter int unsigned STAR_COUNT = srp_pkg::STAR_COUNT_DEF,
    parameter int unsigned IDX_W      = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [srp_pkg::POINT_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [srp_pkg::POINT_W-1:0] wr_data,
    output logic                        busy
);
    import srp_pkg::*;

    logic [POINT_W-1:0] mem [STAR_COUNT];
    logic [POINT_W-1:0] rd_data_reg;
    logic               clearing_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [POINT_W-1:0] mem_wdata;

    // The clearing pass walks every entry once after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_cnt_reg == IDX_W'(STAR_COUNT - 1)) begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Clearing owns the write port; no word is in flight while it runs.
    always_comb begin
        mem_we    = clearing_reg || wr_en;
        mem_waddr = clearing_reg ? clr_cnt_reg : wr_addr;
        mem_wdata = clearing_reg ? '0 : wr_data;
    end

    // Read-first memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// File: src/srp_rot.sv
// One registered plane rotation with Q2.14 floor and saturation of both outputs.
module srp_rot (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [srp_pkg::CFG_W-1:0] cos_val,
    input  logic signed [srp_pkg::CFG_W-1:0] sin_val,
    input  logic signed [srp_pkg::ROT_W-1:0] a_in,
    input  logic signed [srp_pkg::ROT_W-1:0] b_in,
    output logic signed [srp_pkg::ROT_W-1:0] a_out,
    output logic signed [srp_pkg::ROT_W-1:0] b_out
);
    import srp_pkg::*;

    logic signed [PROD_W-1:0] sum_a;
    logic signed [PROD_W-1:0] sum_b;
    logic signed [PROD_W-1:0] fl_a;
    logic signed [PROD_W-1:0] fl_b;
    logic signed [ROT_W-1:0]  a_next;
    logic signed [ROT_W-1:0]  b_next;
    logic signed [ROT_W-1:0]  a_reg;
    logic signed [ROT_W-1:0]  b_reg;

    // Rotate, floor by an arithmetic shift, then clamp to the coordinate range.
    always_comb begin
        sum_a = PROD_W'(cos_val) * PROD_W'(a_in) - PROD_W'(sin_val) * PROD_W'(b_in);
        sum_b = PROD_W'(sin_val) * PROD_W'(a_in) + PROD_W'(cos_val) * PROD_W'(b_in);
        fl_a  = sum_a >>> Q14_SH;
        fl_b  = sum_b >>> Q14_SH;
        if (fl_a > PROD_W'(ROT_MAX)) begin
            a_next = ROT_W'(ROT_MAX);
        end else if (fl_a < PROD_W'(ROT_MIN)) begin
            a_next = ROT_W'(ROT_MIN);
        end else begin
            a_next = fl_a[ROT_W-1:0];
        end
        if (fl_b > PROD_W'(ROT_MAX)) begin
            b_next = ROT_W'(ROT_MAX);
        end else if (fl_b < PROD_W'(ROT_MIN)) begin
            b_next = ROT_W'(ROT_MIN);
        end else begin
            b_next = fl_b[ROT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;

endmodule

// File: src/srp_div.sv
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
module srp_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [srp_pkg::NUM_W-1:0]   num,
    input  logic [srp_pkg::DEN_W-1:0]   den,
    output logic [srp_pkg::NUM_W-1:0]   quo
);
    import srp_pkg::*;

    logic [DEN_W-1:0] r_in  [NUM_W];
    logic [NUM_W-1:0] n_in  [NUM_W];
    logic [DEN_W-1:0] d_in  [NUM_W];
    logic [NUM_W-1:0] q_in  [NUM_W];
    logic [DEN_W-1:0] r_reg [NUM_W];
    logic [NUM_W-1:0] n_reg [NUM_W];
    logic [DEN_W-1:0] d_reg [NUM_W];
    logic [NUM_W-1:0] q_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        // Stage inputs come from the ports or from the previous stage.
        if (k == 0) begin : g_first
            assign r_in[k] = '0;
            assign n_in[k] = num;
            assign d_in[k] = den;
            assign q_in[k] = '0;
        end else begin : g_next
            assign r_in[k] = r_reg[k-1];
            assign n_in[k] = n_reg[k-1];
            assign d_in[k] = d_reg[k-1];
            assign q_in[k] = q_reg[k-1];
        end

        // Shift in the next numerator bit and subtract the divisor if it fits.
        assign trial = {r_in[k], n_in[k][NUM_W-1]};
        assign diff  = trial - {1'b0, d_in[k]};
        assign ge    = trial >= {1'b0, d_in[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                n_reg[k] <= n_in[k] << 1;
                d_reg[k] <= d_in[k];
                q_reg[k] <= {q_in[k][NUM_W-2:0], ge};
            end
        end
    end

    assign quo = q_reg[NUM_W-1];

endmodule

// File: src/star_rotate_project.sv
// Top level: star point rotation, old/new perspective projection and shading.
// Pipeline: the store read and the s0 register take an accepted word, followed by
// 3 rotations, 19 divider stages and the output register; one word per cycle is
// sustained while m_tready keeps the pipeline advancing.
// The four projections run in four pipelined dividers, one quotient bit per stage.
// Reset is synchronous and active low; it then clears the point store, one entry
// per cycle, and s_tready stays low until the clearing pass is done.
module star_rotate_project #(
    parameter int unsigned STAR_COUNT = srp_pkg::STAR_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // star_index[6:0], point_x[16:7], point_y[26:17], point_z[36:27], zero fill.
    input  logic [srp_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // old_screen_x[11:0], old_screen_y[23:12], new_screen_x[35:24],
    // new_screen_y[47:36], shade[55:48].
    output logic [srp_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [srp_pkg::CFG_W-1:0] cfg_data
);
    import srp_pkg::*;

    localparam int unsigned IDX_W = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

    // Configuration registers.
    logic signed [CFG_W-1:0] cos_reg;
    logic signed [CFG_W-1:0] sin_reg;
    logic [CTR_W-1:0]        cx_reg;
    logic [CTR_W-1:0]        cy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg <= COS_RST;
            sin_reg <= SIN_RST;
            cx_reg  <= CX_RST;
            cy_reg  <= CY_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_COS: cos_reg <= cfg_data;
                REG_SIN: sin_reg <= cfg_data;
                REG_CX:  cx_reg  <= cfg_data[CTR_W-1:0];
                REG_CY:  cy_reg  <= cfg_data[CTR_W-1:0];
                default: ;
            endcase
        end
    end

    // Global pipeline advance: moves whenever the output register can take a word.
    logic en;
    logic busy;
    logic accept;
    logic m_tvalid_reg;
    logic [IDX_W-1:0] in_idx;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && !busy;
    assign accept   = s_tvalid && s_tready;
    assign in_idx   = IDX_W'(idx_mod(s_tdata[IDX_IN_W-1:0], STAR_COUNT));

    // Stage registers: s0 (store read), s1..s3 (after each rotation).
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0] idx0_reg, idx1_reg, idx2_reg, idx3_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, z0_reg;
    logic signed [ROT_W-1:0]   x1_reg, y2_reg, z3_reg;
    logic signed [ROT_W-1:0]   y1, z1, x2, z2, x3, y3;
    logic fwd0_reg;
    logic [POINT_W-1:0] fwd_data0_reg;
    logic [POINT_W-1:0] old1_reg, old2_reg, old3_reg;
    logic [POINT_W-1:0] old0;
    logic [POINT_W-1:0] p3;
    logic [POINT_W-1:0] rd_data;
    logic wr_fire;

    assign p3      = {x3, y3, z3_reg};
    assign wr_fire = en && v3_reg;

    // A point still in flight for the same star overrides the stored one.
    assign old0 = fwd0_reg ? fwd_data0_reg : rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload moves with the valid bits; stage three snoops its write into younger words.
    always_ff @(posedge aclk) begin
        if (en) begin
            idx0_reg      <= in_idx;
            x0_reg        <= s_tdata[16:7];
            y0_reg        <= s_tdata[26:17];
            z0_reg        <= s_tdata[36:27];
            fwd0_reg      <= v3_reg && (idx3_reg == in_idx);
            fwd_data0_reg <= p3;
            idx1_reg      <= idx0_reg;
            idx2_reg      <= idx1_reg;
            idx3_reg      <= idx2_reg;
            x1_reg        <= ROT_W'(x0_reg);
            y2_reg        <= y1;
            z3_reg        <= z2;
            old1_reg      <= (v3_reg && idx3_reg == idx0_reg) ? p3 : old0;
            old2_reg      <= (v3_reg && idx3_reg == idx1_reg) ? p3 : old1_reg;
            old3_reg      <= (v3_reg && idx3_reg == idx2_reg) ? p3 : old2_reg;
        end
    end

    srp_store #(
        .STAR_COUNT (STAR_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (en),
        .rd_addr (in_idx),
        .rd_data (rd_data),
        .wr_en   (wr_fire),
        .wr_addr (idx3_reg),
        .wr_data (p3),
        .busy    (busy)
    );

    // Rotations in the y-z, x-z and x-y planes.
    srp_rot u_rot_yz (
        .aclk    (aclk),
        .en      (en),
        .cos_val (cos_reg),
        .sin_val (sin_reg),
        .a_in    (ROT_W'(y0_reg)),
        .b_in    (ROT_W'(z0_reg)),
        .a_out   (y1),
        .b_out   (z1)
    );

    srp_rot u_rot_xz (
        .aclk    (aclk),
        .en      (en),
        .cos_val (cos_reg),
        .sin_val (sin_reg),
        .a_in    (x1_reg),
        .b_in    (z1),
        .a_out   (x2),
        .b_out   (z2)
    );

    srp_rot u_rot_xy (
        .aclk    (aclk),
        .en      (en),
        .cos_val (cos_reg),
        .sin_val (sin_reg),
        .a_in    (x2),
        .b_in    (y2_reg),
        .a_out   (x3),
        .b_out   (y3)
    );

    // Divider lanes: old x, old y, new x, new y.
    logic signed [ROT_W-1:0] lane_v [4];
    logic signed [ROT_W-1:0] lane_z [4];
    logic [NUM_W-1:0]        lane_num [4];
    logic [DEN_W-1:0]        lane_den [4];
    logic [NUM_W-1:0]        lane_quo [4];
    logic [3:0]              lane_neg;

    assign lane_v[0] = old3_reg[3*ROT_W-1:2*ROT_W];
    assign lane_v[1] = old3_reg[2*ROT_W-1:ROT_W];
    assign lane_v[2] = x3;
    assign lane_v[3] = y3;
    assign lane_z[0] = old3_reg[ROT_W-1:0];
    assign lane_z[1] = old3_reg[ROT_W-1:0];
    assign lane_z[2] = z3_reg;
    assign lane_z[3] = z3_reg;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        logic [ROT_W-1:0]        mag;
        logic signed [DEN_W:0]   den_full;

        // The divisor z - 1024 is always negative: divide magnitudes, fix the sign later.
        assign mag          = lane_v[i][ROT_W-1] ? ROT_W'(-lane_v[i]) : ROT_W'(lane_v[i]);
        assign lane_num[i]  = {mag, PROJ_SH'(0)};
        assign den_full     = (DEN_W+1)'(DEPTH_OFS) - (DEN_W+1)'(lane_z[i]);
        assign lane_den[i]  = den_full[DEN_W-1:0];
        assign lane_neg[i]  = !lane_v[i][ROT_W-1] && (lane_v[i] != '0);

        srp_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (lane_num[i]),
            .den  (lane_den[i]),
            .quo  (lane_quo[i])
        );
    end

    // Shade: floor(2*(z+721)/11) through a reciprocal multiply, clamped to 0..255.
    logic signed [DEN_W-1:0] shade_t;
    logic [DEN_W-1:0]        shade_num;
    logic [24:0]             shade_prod;
    logic [8:0]              shade_q;
    logic [SHADE_W-1:0]      shade3;

    always_comb begin
        shade_t    = DEN_W'(z3_reg) + DEN_W'(SHADE_OFS);
        shade_num  = {shade_t[DEN_W-2:0], 1'b0};
        shade_prod = 25'(shade_num) * 25'(SHADE_RECIP);
        shade_q    = shade_prod[SHADE_SH+8:SHADE_SH];
        if (shade_t[DEN_W-1]) begin
            shade3 = '0;
        end else if (shade_q[8]) begin
            shade3 = '1;
        end else begin
            shade3 = shade_q[SHADE_W-1:0];
        end
    end

    // Sideband delay line that runs beside the divider stages.
    logic               sv_reg    [NUM_W];
    logic [3:0]         sneg_reg  [NUM_W];
    logic [SHADE_W-1:0] sshade_reg[NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_side
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sv_reg[k] <= 1'b0;
                end else if (en) begin
                    sv_reg[k] <= v3_reg;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    sneg_reg[k]   <= lane_neg;
                    sshade_reg[k] <= shade3;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sv_reg[k] <= 1'b0;
                end else if (en) begin
                    sv_reg[k] <= sv_reg[k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    sneg_reg[k]   <= sneg_reg[k-1];
                    sshade_reg[k] <= sshade_reg[k-1];
                end
            end
        end
    end

    // Apply the quotient sign, add the screen center and clamp.
    logic [SCR_W-1:0] scr [4];

    for (genvar i = 0; i < 4; i++) begin : g_fin
        logic signed [SUM_W-1:0] sq;
        logic signed [SUM_W-1:0] sum;
        logic [CTR_W-1:0]        ctr;

        assign ctr = (i == 0 || i == 2) ? cx_reg : cy_reg;
        assign sq  = sneg_reg[NUM_W-1][i] ? -SUM_W'(lane_quo[i]) : SUM_W'(lane_quo[i]);
        assign sum = sq + SUM_W'(ctr);

        always_comb begin
            if (sum > SUM_W'(SCR_MAX)) begin
                scr[i] = SCR_W'(SCR_MAX);
            end else if (sum < SUM_W'(SCR_MIN)) begin
                scr[i] = SCR_W'(SCR_MIN);
            end else begin
                scr[i] = sum[SCR_W-1:0];
            end
        end
    end

    // Output register.
    logic [OUT_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= sv_reg[NUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {sshade_reg[NUM_W-1], scr[3], scr[2], scr[1], scr[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
